/* hdl/sha_pkg.sv */
// Package: SHA-256 constants, types and round helper functions.
`timescale 1ns / 1ps
package sha_pkg;

    localparam int unsigned NumRounds = 64;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned NumWords = 8;
    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos = 6'd56;

    typedef logic [31:0] t_word;
    typedef logic [7:0] t_byte;

    localparam t_word RoundConst [NumRounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word InitHash [NumWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_core_ctl;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word ssig0(input t_word x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word ssig1(input t_word x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word bsig0(input t_word x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

/* hdl/sha_if.sv */
// Interfaces: valid/ready channels for input bytes and digest words.
`timescale 1ns / 1ps
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* hdl/sha_core.sv */
// SHA-256 compression core: one round per cycle, rolling 16-word schedule.
`timescale 1ns / 1ps
module sha_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha_pkg::t_core_ctl  i_ctl,
    input  sha_pkg::t_word      i_chain [sha_pkg::NumWords],
    input  sha_pkg::t_word      i_block [16],
    output sha_pkg::t_core_ctl  o_ctl,
    output sha_pkg::t_word      o_chain [sha_pkg::NumWords]
);
    sha_pkg::t_word r_v [8];
    sha_pkg::t_word r_w [16];
    logic [5:0]     r_round;
    logic           r_busy;
    logic           r_done;
    sha_pkg::t_word t1, t2, wn, e, a;

    always_comb begin
        e  = r_v[4];
        a  = r_v[0];
        t1 = r_v[7] + sha_pkg::bsig1(e) + ((e & r_v[5]) ^ (~e & r_v[6]))
             + sha_pkg::RoundConst[r_round] + r_w[0];
        t2 = sha_pkg::bsig0(a) + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
        wn = sha_pkg::ssig1(r_w[14]) + r_w[9] + sha_pkg::ssig0(r_w[1]) + r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start && !r_busy) begin
            for (int i = 0; i < 8; i++) r_v[i] <= i_chain[i];
            for (int i = 0; i < 16; i++) r_w[i] <= i_block[i];
        end else if (r_busy) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= wn;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) o_chain[i] = r_v[i];
        o_ctl.start = 1'b0;
        o_ctl.busy  = r_busy;
        o_ctl.done  = r_done;
    end
endmodule

/* hdl/sha256_byte_stream_hasher.sv */
// Top level: byte buffering, padding sequencer and digest output.
`timescale 1ns / 1ps
// SHA-256 hasher fed one byte per transaction on i_in (valid/ready).
// byte_present marks a message byte; end_of_message closes the message,
// possibly with no byte (empty message allowed).
// A byte that neither fills a block nor closes the message leaves i_in.ready
// high. A byte that fills a block drops i_in.ready through launch, 64 rounds
// and chaining update, so the next transaction waits on the single round unit
// doing one round per cycle.
// At end of message: the PAD state builds the padded block, then each padding
// block (one or two) is compressed before the first digest word is valid; a
// closing byte that filled a block has that block compressed first.
// Eight digest words then leave on o_out, word 0 first, last_word on word 7,
// one per cycle while the receiver takes them; the WAIT state then restores the
// initial hash values before i_in.ready returns.
// i_in.ready is low throughout compression and digest output.
// If the receiver stalls, the current digest word holds until taken.
// Synchronous reset loads the initial hash values and clears the byte count.
module sha256_byte_stream_hasher (
    input  logic i_clk,
    input  logic i_rst_n,
    sha_in_if.sink    i_in,
    sha_out_if.source o_out
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_COMP  = 6'b000010,
        ST_PAD   = 6'b000100,
        ST_PCOMP = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_WAIT  = 6'b100000
    } t_state;

    t_state              r_state;
    sha_pkg::t_word      r_buf [16];
    sha_pkg::t_word      r_h [8];
    logic [60:0]         r_count;
    logic                r_final;
    logic                r_second;
    logic [2:0]          r_idx;
    sha_pkg::t_core_ctl  core_in, core_out;
    sha_pkg::t_word      core_chain [8];
    sha_pkg::t_word      n_pad [16];
    sha_pkg::t_word      pad_keep;
    sha_pkg::t_word      pad_mark;
    logic                acc;
    logic [63:0]         bits;

    assign acc  = i_in.valid && i_in.ready;
    assign bits = {r_count, 3'b000};
    assign i_in.ready = (r_state == ST_IDLE);

    always_comb begin
        core_in.start = (r_state == ST_COMP || r_state == ST_PCOMP) && !core_out.busy
                        && !core_out.done && !r_second;
        core_in.busy  = 1'b0;
        core_in.done  = 1'b0;
    end

    // padded block: bytes kept before the pad mark, zeros after, length if it fits
    always_comb begin
        unique case (r_count[1:0])
            2'd0: begin
                pad_keep = 32'h0000_0000;
                pad_mark = {sha_pkg::PadByte, 24'h0};
            end
            2'd1: begin
                pad_keep = 32'hff00_0000;
                pad_mark = {8'h0, sha_pkg::PadByte, 16'h0};
            end
            2'd2: begin
                pad_keep = 32'hffff_0000;
                pad_mark = {16'h0, sha_pkg::PadByte, 8'h0};
            end
            2'd3: begin
                pad_keep = 32'hffff_ff00;
                pad_mark = {24'h0, sha_pkg::PadByte};
            end
        endcase
        for (int i = 0; i < 16; i++) begin
            if (i < int'(r_count[5:2])) n_pad[i] = r_buf[i];
            else if (i == int'(r_count[5:2])) n_pad[i] = (r_buf[i] & pad_keep) | pad_mark;
            else n_pad[i] = '0;
        end
        if (r_count[5:0] < sha_pkg::LenPos) begin
            n_pad[14] = bits[63:32];
            n_pad[15] = bits[31:0];
        end
    end

    sha_core u_core (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (core_in), .i_chain (r_h),
        .i_block (r_buf), .o_ctl (core_out), .o_chain (core_chain)
    );

    // r_second marks that compression has been launched in the current state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_final  <= 1'b0;
            r_second <= 1'b0;
            r_idx    <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::InitHash[i];
        end else begin
            if (core_in.start) r_second <= 1'b1;
            unique case (r_state)
                ST_IDLE: if (acc) begin
                    if (i_in.byte_present) begin
                        unique case (r_count[1:0])
                            2'd0: r_buf[r_count[5:2]][31:24] <= i_in.data_byte;
                            2'd1: r_buf[r_count[5:2]][23:16] <= i_in.data_byte;
                            2'd2: r_buf[r_count[5:2]][15:8]  <= i_in.data_byte;
                            2'd3: r_buf[r_count[5:2]][7:0]   <= i_in.data_byte;
                        endcase
                        r_count <= r_count + 61'd1;
                    end
                    r_final <= i_in.end_of_message;
                    if (i_in.byte_present && r_count[5:0] == 6'd63) r_state <= ST_COMP;
                    else if (i_in.end_of_message) r_state <= ST_PAD;
                end
                ST_COMP: if (core_out.done) begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + core_chain[i];
                    r_second <= 1'b0;
                    r_state  <= r_final ? ST_PAD : ST_IDLE;
                end
                ST_PAD: begin
                    for (int i = 0; i < 16; i++) r_buf[i] <= n_pad[i];
                    r_final <= (r_count[5:0] >= sha_pkg::LenPos);
                    r_state <= ST_PCOMP;
                end
                ST_PCOMP: if (core_out.done) begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + core_chain[i];
                    r_second <= 1'b0;
                    if (r_final) begin
                        for (int i = 0; i < 14; i++) r_buf[i] <= '0;
                        r_buf[14] <= bits[63:32];
                        r_buf[15] <= bits[31:0];
                        r_final   <= 1'b0;
                    end else begin
                        r_idx   <= '0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: if (o_out.ready) begin
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd7) r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::InitHash[i];
                    r_count <= '0;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid       = (r_state == ST_EMIT);
    assign o_out.digest_word = r_h[r_idx];
    assign o_out.word_index  = r_idx;
    assign o_out.last_word   = (r_idx == 3'd7);

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_out.busy |-> !i_in.ready) else $error("input taken during compression");
    a_last_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_word) |=> r_state == ST_WAIT)
        else $error("digest did not end after last word");
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_out.done |-> (r_state == ST_COMP || r_state == ST_PCOMP))
        else $error("compression finished outside a compress state");
endmodule
